@@ hw/rtl/round_robin_thread_scheduler_assert.svh @@
// Assertion macros used by the scheduler checker.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RRTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rrts_pkg.sv @@
// Types, codes and constants of the round-robin thread scheduler.
package rrts_pkg;

  localparam int MAX_THREADS_DEF = 16;

  // Operation codes carried by an input word
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_UNBLOCK = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_EXIT    = 3'd3,
    OP_SCHED   = 3'd4,
    OP_SET_CUR = 3'd5
  } op_e;

  // Per-thread status codes
  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } thread_st_e;

  // Result status codes
  typedef enum logic [1:0] {
    RES_DONE    = 2'd0,
    RES_IGNORED = 2'd1,
    RES_ERROR   = 2'd2
  } res_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] thread_id;
    logic       user_space;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       switched;
    logic [3:0] prev_thread;
    logic [3:0] next_thread;
    logic       load_kernel_stack;
    logic [3:0] active_thread;
    logic       current_valid;
  } result_t;

endpackage

@@ hw/rtl/rrts_core.sv @@
// Thread table, ready queue and single-pass operation logic.
module rrts_core import rrts_pkg::*; #(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  localparam int IDX_W = $clog2(MAX_THREADS);

  // Thread table
  logic [1:0]       status_r [MAX_THREADS];
  logic             queued_r [MAX_THREADS];
  logic [IDX_W-1:0] link_r   [MAX_THREADS];
  logic             user_r   [MAX_THREADS];

  // Queue pointers and current thread
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [IDX_W-1:0] run_id_r, run_id_nxt;
  logic             run_vld_r, run_vld_nxt;

  // Table write ports
  logic             st_we0, st_we1;
  logic [IDX_W-1:0] st_a0;
  logic [1:0]       st_d0;
  logic             lk_we;
  logic [IDX_W-1:0] lk_a, lk_d;
  logic             usr_we, usr_d;
  logic             q_clr_we, q_set_we;
  logic [IDX_W-1:0] q_set_a;

  logic [IDX_W-1:0] t;
  logic             id_ok;
  logic             can_sched, do_sched, sched_op, run_is_running, requeue, pop_last;
  logic [1:0]       res_status;

  assign t         = IDX_W'(item.thread_id);
  assign id_ok     = 32'(item.thread_id) < 32'(MAX_THREADS);
  assign can_sched = run_vld_r && !empty_r;
  assign pop_last  = (head_r == tail_r);
  assign run_is_running = (status_r[run_id_r] == ST_RUNNING);

  // Decode the operation and plan all state updates
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    empty_nxt   = empty_r;
    run_id_nxt  = run_id_r;
    run_vld_nxt = run_vld_r;
    st_we0      = 1'b0;
    st_a0       = t;
    st_d0       = ST_READY;
    st_we1      = 1'b0;
    lk_we       = 1'b0;
    lk_a        = t;
    lk_d        = head_r;
    usr_we      = 1'b0;
    usr_d       = 1'b0;
    q_clr_we    = 1'b0;
    q_set_we    = 1'b0;
    q_set_a     = t;
    do_sched    = 1'b0;
    sched_op    = 1'b0;
    requeue     = 1'b0;
    res_status  = RES_IGNORED;

    unique case (item.operation)
      OP_ADD: begin
        if (id_ok) begin
          if (queued_r[t]) begin
            res_status = RES_ERROR;
          end else begin
            st_we0   = 1'b1;
            usr_we   = 1'b1;
            usr_d    = item.user_space;
            if (empty_r) begin
              tail_nxt  = t;
              empty_nxt = 1'b0;
            end else begin
              lk_we = 1'b1;
            end
            head_nxt   = t;
            q_set_we   = 1'b1;
            res_status = RES_DONE;
          end
        end
      end
      OP_UNBLOCK: begin
        if (id_ok && status_r[t] == ST_BLOCKED) begin
          st_we0 = 1'b1;
          if (!queued_r[t]) begin
            if (empty_r) begin
              head_nxt  = t;
              empty_nxt = 1'b0;
            end else begin
              lk_we = 1'b1;
              lk_a  = tail_r;
              lk_d  = t;
            end
            tail_nxt = t;
            q_set_we = 1'b1;
          end
          res_status = RES_DONE;
        end
      end
      OP_BLOCK, OP_EXIT: begin
        if (run_vld_r) begin
          st_we0     = 1'b1;
          st_a0      = run_id_r;
          st_d0      = (item.operation == OP_BLOCK) ? ST_BLOCKED : ST_FREE;
          res_status = RES_DONE;
          do_sched   = can_sched;
        end
      end
      OP_SCHED: begin
        if (can_sched) begin
          do_sched   = 1'b1;
          sched_op   = 1'b1;
          res_status = RES_DONE;
        end
      end
      OP_SET_CUR: begin
        if (id_ok) begin
          run_id_nxt  = t;
          run_vld_nxt = 1'b1;
          st_we0      = 1'b1;
          usr_we      = 1'b1;
          res_status  = RES_DONE;
        end
      end
      default: begin
      end
    endcase

    // Pop the head; on OP_SCHED put a running current thread back at the tail unless queued elsewhere
    if (do_sched) begin
      q_clr_we = 1'b1;
      st_we1   = 1'b1;
      if (sched_op && run_is_running) begin
        st_we0 = 1'b1;
        st_a0  = run_id_r;
        st_d0  = ST_READY;
      end
      requeue = sched_op && run_is_running &&
                !(queued_r[run_id_r] && (run_id_r != head_r));
      if (requeue) begin
        q_set_we = 1'b1;
        q_set_a  = run_id_r;
        tail_nxt = run_id_r;
        if (pop_last) begin
          head_nxt  = run_id_r;
          empty_nxt = 1'b0;
        end else begin
          head_nxt = link_r[head_r];
          lk_we    = 1'b1;
          lk_a     = tail_r;
          lk_d     = run_id_r;
        end
      end else begin
        head_nxt  = pop_last ? head_r : link_r[head_r];
        empty_nxt = pop_last;
      end
      run_id_nxt = head_r;
    end
  end

  // Build the result word
  always_comb begin
    result.status            = res_status;
    result.switched          = do_sched;
    result.prev_thread       = do_sched ? 4'(run_id_r) : 4'd0;
    result.next_thread       = do_sched ? 4'(head_r) : 4'd0;
    result.load_kernel_stack = do_sched ? user_r[head_r] : 1'b0;
    result.active_thread     = run_vld_nxt ? 4'(run_id_nxt) : 4'd0;
    result.current_valid     = run_vld_nxt;
  end

  // Update status, queue flags and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        status_r[i] <= ST_FREE;
        queued_r[i] <= 1'b0;
      end
      head_r    <= '0;
      tail_r    <= '0;
      empty_r   <= 1'b1;
      run_id_r  <= '0;
      run_vld_r <= 1'b0;
    end else if (fire) begin
      if (st_we0) begin
        status_r[st_a0] <= st_d0;
      end
      if (st_we1) begin
        status_r[head_r] <= ST_RUNNING;
      end
      if (q_clr_we) begin
        queued_r[head_r] <= 1'b0;
      end
      if (q_set_we) begin
        queued_r[q_set_a] <= 1'b1;
      end
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      empty_r   <= empty_nxt;
      run_id_r  <= run_id_nxt;
      run_vld_r <= run_vld_nxt;
    end
  end

  // Links and address-space flags hold whatever was last written
  always_ff @(posedge clk) begin
    if (fire) begin
      if (lk_we) begin
        link_r[lk_a] <= lk_d;
      end
      if (usr_we) begin
        user_r[t] <= usr_d;
      end
    end
  end

endmodule

@@ hw/rtl/round_robin_thread_scheduler.sv @@
// Top level of the round-robin thread scheduler: input and result registers around the core.
//
//   channel   ports                          carries
//   in        in_valid  in_ready  in_data    item_t: operation, thread_id, user_space
//   out       out_valid out_ready out_data   result_t: status, switch report, current
//
// One item per cycle unless the result stalls; a taken item passes the input then the output register.
// Each item updates the thread table and queue pointers in one pass between the registers.
// rst_n is synchronous: all threads free, queue empty, no current thread, both stages empty.
// A stalled result holds in the output register while one more item waits in the input
// register; in_ready drops only when both are full.
module round_robin_thread_scheduler import rrts_pkg::*; #(
  parameter int MAX_THREADS = MAX_THREADS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    s1_vld_r, s1_vld_nxt;
  item_t   s1_data_r;
  logic    out_vld_r, out_vld_nxt;
  result_t out_data_r;
  result_t core_res;
  logic    fire;
  logic    in_take;

  // Advance the held word when the result register is free
  assign fire     = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || fire;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : s1_vld_r);
    out_vld_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  rrts_core #(
    .MAX_THREADS(MAX_THREADS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_data_r),
    .result (core_res)
  );

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/rrts_checker.sv @@
// Port-level checker for the round-robin thread scheduler, bound to the top level.
`include "round_robin_thread_scheduler_assert.svh"

module rrts_checker import rrts_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input item_t   in_data,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  logic out_stall;
  logic sw_word;
  logic plain_word;
  logic sw_ok;
  logic sw_fields_zero;

  // Classify the offered result word
  assign out_stall      = out_valid && !out_ready;
  assign sw_word        = out_valid && out_data.switched;
  assign plain_word     = out_valid && !out_data.switched;
  assign sw_ok          = (out_data.status == RES_DONE) && out_data.current_valid &&
                          (out_data.active_thread == out_data.next_thread);
  assign sw_fields_zero = (out_data.prev_thread == 4'd0) && (out_data.next_thread == 4'd0) &&
                          !out_data.load_kernel_stack;

  // Hold a stalled result
  `RRTS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "held result changed")

  // Input side backs up only behind a stalled result
  `RRTS_ASSERT_NOW(a_in_stall, !in_ready, out_stall, "input stalled without a result stall")

  // A switch always completes the operation and installs the next thread
  `RRTS_ASSERT_NOW(a_switch_cur, sw_word, sw_ok, "switch report disagrees with current")

  // Without a switch the switch report is zero
  `RRTS_ASSERT_NOW(a_noswitch_zero, plain_word, sw_fields_zero, "switch fields without a switch")

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (.*);
